// File: sv/fbt_pkg.sv
// Package: shared constants, types and codes of the failure ban table.
`default_nettype none
package fbt_pkg;
   localparam int COUNT_ENTRIES = 16;
   localparam int BAN_ENTRIES   = 16;
   localparam int ALLOW_ENTRIES = 4;
   localparam int CIDX_W = $clog2(COUNT_ENTRIES);
   localparam int BIDX_W = $clog2(BAN_ENTRIES);
   localparam int CCNT_W = $clog2(COUNT_ENTRIES + 1);
   localparam int BCNT_W = $clog2(BAN_ENTRIES + 1);

   localparam logic [2:0] CMD_FAIL   = 3'd0;
   localparam logic [2:0] CMD_UNFAIL = 3'd1;
   localparam logic [2:0] CMD_BAN    = 3'd2;
   localparam logic [2:0] CMD_QUERY  = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   localparam logic [1:0] EV_REPLY  = 2'd0;
   localparam logic [1:0] EV_LIFTED = 2'd1;
   localparam logic [1:0] EV_TICK   = 2'd2;

   localparam logic [2:0] REG_FAIL_LIMIT  = 3'd0;
   localparam logic [2:0] REG_FAIL_WINDOW = 3'd1;
   localparam logic [2:0] REG_BAN_LENGTH  = 3'd2;
   localparam logic [2:0] REG_ALLOW_0     = 3'd3;
   localparam logic [2:0] REG_ALLOW_1     = 3'd4;
   localparam logic [2:0] REG_ALLOW_2     = 3'd5;
   localparam logic [2:0] REG_ALLOW_3     = 3'd6;
   localparam logic [2:0] REG_ALLOW_USED  = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CSCAN, ST_BSCAN, ST_EXEC, ST_TBAN, ST_TCNT, ST_TEND, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture transaction
      logic cscan;      // examine count entry at index
      logic bscan;      // examine ban entry at index
      logic exec;       // apply command
      logic tick_inc;   // advance time
      logic tban;       // tick: test ban entry
      logic tcnt;       // tick: test count entry
      logic tend;       // build tick-finished result
      logic clr_idx;    // restart scan index
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] command;
      logic       cdone;
      logic       bdone;
      logic       lift;   // current ban entry valid and expired; in a tick, its result is built
   } stat_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] address_out;
      logic        ok;
      logic        banned_now;
      logic        table_full;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// File: sv/fbt_if.sv
// Interfaces: request, response and register-write channels.
`default_nettype none
interface fbt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [31:0] address;
   modport source (output valid, command, address, input ready);
   modport sink   (input valid, command, address, output ready);
endinterface

interface fbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [31:0] address_out;
   logic        ok;
   logic        banned_now;
   logic        table_full;
   logic        last;
   modport source (output valid, event_kind, address_out, ok, banned_now, table_full, last,
                   input ready);
   modport sink   (input valid, event_kind, address_out, ok, banned_now, table_full, last,
                   output ready);
endinterface

interface fbt_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/failure_ban_table.sv
// Top level: failure counter and ban list block.
// Each transaction is handled alone. A command other than tick scans the
// 16-entry counter table and then the 16-entry ban table, one entry a cycle,
// then executes and shows its reply, which output stall can hold. A tick
// advances time, walks the ban table one entry a cycle, held while a lifted
// ban's result is shown, and then the counter table, then gives the
// tick-finished result, which output stall can hold. Scan length is set by
// the table depths. Register writes are always accepted.
`default_nettype none
module failure_ban_table (
   input  wire logic  clock,
   input  wire logic  reset,
   fbt_req_if.sink    req,
   fbt_rsp_if.source  rsp,
   fbt_csr_if.sink    csr
);
   fbt_pkg::cmd_type  cmd;
   fbt_pkg::stat_type stat;
   fbt_pkg::rsp_type  res;

   assign csr.ready = 1'b1;

   fbt_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat, .cmd
   );

   fbt_dp u_dp (
      .clock, .reset, .cmd, .stat,
      .req_command (req.command),
      .req_address (req.address),
      .csr_we      (csr.valid),
      .csr_index   (csr.index),
      .csr_data    (csr.data),
      .rsp         (res)
   );

   assign rsp.event_kind  = res.event_kind;
   assign rsp.address_out = res.address_out;
   assign rsp.ok          = res.ok;
   assign rsp.banned_now  = res.banned_now;
   assign rsp.table_full  = res.table_full;
   assign rsp.last        = res.last;
endmodule
`default_nettype wire

// File: sv/fbt_ctrl.sv
// Controller: sequences scans, command execution and tick results.
`default_nettype none
module fbt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire fbt_pkg::stat_type stat,
   output fbt_pkg::cmd_type       cmd
);
   fbt_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbt_pkg::ST_IDLE;
         ret_ff   <= fbt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         fbt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.clr_idx = 1'b1;
               state_in    = fbt_pkg::ST_CSCAN;
            end
         end
         fbt_pkg::ST_CSCAN: begin
            if (stat.command == fbt_pkg::CMD_TICK) begin
               cmd.tick_inc = 1'b1;
               cmd.clr_idx  = 1'b1;
               state_in     = fbt_pkg::ST_TBAN;
            end else begin
               cmd.cscan = 1'b1;
               if (stat.cdone) begin
                  cmd.clr_idx = 1'b1;
                  state_in    = fbt_pkg::ST_BSCAN;
               end
            end
         end
         fbt_pkg::ST_BSCAN: begin
            cmd.bscan = 1'b1;
            if (stat.bdone) state_in = fbt_pkg::ST_EXEC;
         end
         fbt_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            ret_in   = fbt_pkg::ST_IDLE;
            state_in = fbt_pkg::ST_OUT;
         end
         fbt_pkg::ST_TBAN: begin
            cmd.tban = 1'b1;
            if (stat.lift) begin
               ret_in   = fbt_pkg::ST_TBAN;
               state_in = fbt_pkg::ST_OUT;
            end else if (stat.bdone) begin
               cmd.clr_idx = 1'b1;
               state_in    = fbt_pkg::ST_TCNT;
            end
         end
         fbt_pkg::ST_TCNT: begin
            cmd.tcnt = 1'b1;
            if (stat.cdone) state_in = fbt_pkg::ST_TEND;
         end
         fbt_pkg::ST_TEND: begin
            cmd.tend = 1'b1;
            ret_in   = fbt_pkg::ST_IDLE;
            state_in = fbt_pkg::ST_OUT;
         end
         fbt_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ret_ff;
         end
         default: state_in = fbt_pkg::ST_IDLE;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("accepting while a response is pending");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == fbt_pkg::ST_EXEC |=> state_ff == fbt_pkg::ST_OUT)
      else $error("command reply not presented");
endmodule
`default_nettype wire

// File: sv/fbt_dp.sv
// Datapath: tables, registers, time and result register.
`default_nettype none
module fbt_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fbt_pkg::cmd_type  cmd,
   output fbt_pkg::stat_type      stat,
   input  wire logic [2:0]        req_command,
   input  wire logic [31:0]       req_address,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   output fbt_pkg::rsp_type       rsp
);
   localparam int CW = fbt_pkg::CIDX_W;
   localparam int BW = fbt_pkg::BIDX_W;
   localparam int IW = (CW > BW) ? CW : BW;
   localparam int IDXW = IW + 1;

   // configuration
   logic [7:0]  limit_ff;
   logic [31:0] window_ff, banlen_ff;
   logic [31:0] allow_ff [fbt_pkg::ALLOW_ENTRIES];
   logic [2:0]  used_ff;

   // tables
   logic [31:0] c_addr_ff [fbt_pkg::COUNT_ENTRIES];
   logic [7:0]  c_val_ff  [fbt_pkg::COUNT_ENTRIES];
   logic [31:0] c_time_ff [fbt_pkg::COUNT_ENTRIES];
   logic [fbt_pkg::COUNT_ENTRIES-1:0] c_vld_ff;
   logic [31:0] b_addr_ff [fbt_pkg::BAN_ENTRIES];
   logic [31:0] b_time_ff [fbt_pkg::BAN_ENTRIES];
   logic [fbt_pkg::BAN_ENTRIES-1:0] b_vld_ff;
   logic [31:0] time_ff;

   // transaction and scan results
   logic [2:0]  cmd_ff;
   logic [31:0] addr_ff;
   logic [IDXW-1:0] idx_ff;
   logic        chit_ff, cfree_ff, bhit_ff, bfree_ff;
   logic [CW-1:0] chit_i_ff, cfree_i_ff;
   logic [BW-1:0] bfree_i_ff;
   fbt_pkg::rsp_type rsp_ff;
   fbt_pkg::rsp_type reply;

   logic [CW-1:0] ci;
   logic [BW-1:0] bi;
   logic allowed;
   logic [7:0] nval;
   logic [31:0] b_el, c_el;

   assign ci = idx_ff[CW-1:0];
   assign bi = idx_ff[BW-1:0];
   assign rsp = rsp_ff;
   assign b_el = time_ff - b_time_ff[bi];
   assign c_el = time_ff - c_time_ff[ci];
   assign nval = (c_val_ff[chit_i_ff] == 8'hFF) ? 8'hFF : c_val_ff[chit_i_ff] + 8'd1;

   always_comb begin
      allowed = 1'b0;
      for (int k = 0; k < fbt_pkg::ALLOW_ENTRIES; k++)
         if ({29'd0, used_ff} > k && allow_ff[k] == addr_ff) allowed = 1'b1;
   end

   assign stat.command = cmd_ff;
   assign stat.cdone = (idx_ff == IDXW'(fbt_pkg::COUNT_ENTRIES - 1));
   assign stat.bdone = (idx_ff == IDXW'(fbt_pkg::BAN_ENTRIES - 1));
   assign stat.lift  = b_vld_ff[bi] && (b_el >= banlen_ff);

   // build the command reply from the scan results
   always_comb begin
      reply = '{event_kind: fbt_pkg::EV_REPLY, address_out: addr_ff,
                ok: 1'b0, banned_now: 1'b0, table_full: 1'b0, last: 1'b1};
      unique case (cmd_ff)
         fbt_pkg::CMD_FAIL: begin
            if (!allowed) begin
               reply.ok = 1'b1;
               if (!chit_ff) begin
                  if (!cfree_ff) reply.table_full = 1'b1;
               end else if (nval >= limit_ff && !bhit_ff) begin
                  if (bfree_ff) reply.banned_now = 1'b1;
                  else reply.table_full = 1'b1;
               end
            end
         end
         fbt_pkg::CMD_UNFAIL: reply.ok = chit_ff;
         fbt_pkg::CMD_BAN: begin
            if (!allowed) begin
               reply.ok = 1'b1;
               if (!bhit_ff) begin
                  if (bfree_ff) reply.banned_now = 1'b1;
                  else reply.table_full = 1'b1;
               end
            end
         end
         fbt_pkg::CMD_QUERY: reply.ok = bhit_ff;
         default: ;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= 8'd5;
         window_ff <= 32'd600;
         banlen_ff <= 32'd3600;
         used_ff   <= 3'd0;
         for (int k = 0; k < fbt_pkg::ALLOW_ENTRIES; k++) allow_ff[k] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            fbt_pkg::REG_FAIL_LIMIT:  limit_ff  <= csr_data[7:0];
            fbt_pkg::REG_FAIL_WINDOW: window_ff <= csr_data;
            fbt_pkg::REG_BAN_LENGTH:  banlen_ff <= csr_data;
            fbt_pkg::REG_ALLOW_0:     allow_ff[0] <= csr_data;
            fbt_pkg::REG_ALLOW_1:     allow_ff[1] <= csr_data;
            fbt_pkg::REG_ALLOW_2:     allow_ff[2] <= csr_data;
            fbt_pkg::REG_ALLOW_3:     allow_ff[3] <= csr_data;
            fbt_pkg::REG_ALLOW_USED:  used_ff   <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // control state: valid bits and time
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= '0;
         b_vld_ff <= '0;
         time_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         if (cmd.clr_idx) idx_ff <= '0;
         else if (cmd.cscan || cmd.bscan || cmd.tcnt || (cmd.tban && !stat.lift))
            idx_ff <= idx_ff + IDXW'(1);
         if (cmd.tick_inc) time_ff <= time_ff + 32'd1;
         if (cmd.tban && stat.lift) b_vld_ff[bi] <= 1'b0;
         if (cmd.tcnt && c_vld_ff[ci] && c_el >= window_ff) c_vld_ff[ci] <= 1'b0;
         if (cmd.exec) begin
            unique case (cmd_ff)
               fbt_pkg::CMD_FAIL: begin
                  if (!allowed) begin
                     if (!chit_ff) begin
                        if (cfree_ff) c_vld_ff[cfree_i_ff] <= 1'b1;
                     end else if (nval >= limit_ff) begin
                        c_vld_ff[chit_i_ff] <= 1'b0;
                        if (!bhit_ff && bfree_ff) b_vld_ff[bfree_i_ff] <= 1'b1;
                     end
                  end
               end
               fbt_pkg::CMD_UNFAIL: if (chit_ff) c_vld_ff[chit_i_ff] <= 1'b0;
               fbt_pkg::CMD_BAN:
                  if (!allowed && !bhit_ff && bfree_ff) b_vld_ff[bfree_i_ff] <= 1'b1;
               default: ;
            endcase
         end
      end
   end

   // payload: transaction, scan results, table contents, result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address;
         chit_ff <= 1'b0; cfree_ff <= 1'b0; bhit_ff <= 1'b0; bfree_ff <= 1'b0;
         chit_i_ff <= '0; cfree_i_ff <= '0; bfree_i_ff <= '0;
      end
      if (cmd.cscan) begin
         if (c_vld_ff[ci] && c_addr_ff[ci] == addr_ff && !chit_ff) begin
            chit_ff <= 1'b1; chit_i_ff <= ci;
         end
         if (!c_vld_ff[ci] && !cfree_ff) begin
            cfree_ff <= 1'b1; cfree_i_ff <= ci;
         end
      end
      if (cmd.bscan) begin
         if (b_vld_ff[bi] && b_addr_ff[bi] == addr_ff) bhit_ff <= 1'b1;
         if (!b_vld_ff[bi] && !bfree_ff) begin
            bfree_ff <= 1'b1; bfree_i_ff <= bi;
         end
      end
      if (cmd.tban && stat.lift) begin
         rsp_ff <= '{event_kind: fbt_pkg::EV_LIFTED, address_out: b_addr_ff[bi],
                     ok: 1'b1, banned_now: 1'b0, table_full: 1'b0, last: 1'b0};
      end
      if (cmd.tend) begin
         rsp_ff <= '{event_kind: fbt_pkg::EV_TICK, address_out: 32'd0,
                     ok: 1'b0, banned_now: 1'b0, table_full: 1'b0, last: 1'b1};
      end
      if (cmd.exec) begin
         rsp_ff <= reply;
         unique case (cmd_ff)
            fbt_pkg::CMD_FAIL: begin
               if (!allowed) begin
                  if (!chit_ff) begin
                     if (cfree_ff) begin
                        c_addr_ff[cfree_i_ff] <= addr_ff;
                        c_val_ff[cfree_i_ff]  <= 8'd1;
                        c_time_ff[cfree_i_ff] <= time_ff;
                     end
                  end else begin
                     c_val_ff[chit_i_ff] <= nval;
                     if (nval >= limit_ff && !bhit_ff && bfree_ff) begin
                        b_addr_ff[bfree_i_ff] <= addr_ff;
                        b_time_ff[bfree_i_ff] <= time_ff;
                     end
                  end
               end
            end
            fbt_pkg::CMD_BAN: begin
               if (!allowed && !bhit_ff && bfree_ff) begin
                  b_addr_ff[bfree_i_ff] <= addr_ff;
                  b_time_ff[bfree_i_ff] <= time_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.exec && cmd_ff == fbt_pkg::CMD_BAN && !allowed && !bhit_ff && bfree_ff
      |=> b_vld_ff != '0)
      else $error("ban not recorded");
   assert property (@(posedge clock) disable iff (reset)
      cmd.tend |=> rsp_ff.last && rsp_ff.event_kind == fbt_pkg::EV_TICK)
      else $error("tick end result wrong");
   assert property (@(posedge clock) disable iff (reset)
      cmd.tick_inc |=> time_ff == $past(time_ff) + 32'd1)
      else $error("time not advanced");
endmodule
`default_nettype wire

// File: tb/failure_ban_table_checker.sv
// Checker: watches the channels of the failure ban table, predicts and compares results.
`timescale 1ns / 1ps
module failure_ban_table_checker
   import fbt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   fbt_req_if   req,
   fbt_rsp_if   rsp,
   fbt_csr_if   csr,
   output int   errors,
   output int   waiting
);

   // register copy
   logic [7:0]  lim;
   logic [31:0] window;
   logic [31:0] ban_len;
   logic [31:0] allow_addr [ALLOW_ENTRIES];
   logic [2:0]  allow_n;

   // table copy
   logic [31:0] cnt_addr  [COUNT_ENTRIES];
   logic [7:0]  cnt_val   [COUNT_ENTRIES];
   logic [31:0] cnt_start [COUNT_ENTRIES];
   logic        cnt_used  [COUNT_ENTRIES];
   logic [31:0] ban_addr  [BAN_ENTRIES];
   logic [31:0] ban_start [BAN_ENTRIES];
   logic        ban_used  [BAN_ENTRIES];
   logic [31:0] now;

   rsp_type expected_rsps [$];

   function automatic logic is_allowed(logic [31:0] a);
      int n;
      n = (allow_n > ALLOW_ENTRIES) ? ALLOW_ENTRIES : allow_n;
      for (int i = 0; i < n; i++)
         if (allow_addr[i] == a) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int find_counter(logic [31:0] a);
      for (int i = 0; i < COUNT_ENTRIES; i++)
         if (cnt_used[i] && cnt_addr[i] == a) return i;
      return -1;
   endfunction

   function automatic int find_banned(logic [31:0] a);
      for (int i = 0; i < BAN_ENTRIES; i++)
         if (ban_used[i] && ban_addr[i] == a) return i;
      return -1;
   endfunction

   task automatic push_rsp(logic [1:0] kind, logic [31:0] a, logic ok, logic bn,
                           logic full, logic last);
      rsp_type r;
      r.event_kind  = kind;
      r.address_out = a;
      r.ok          = ok;
      r.banned_now  = bn;
      r.table_full  = full;
      r.last        = last;
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   // store a ban unless present; flag a new entry or a full table
   task automatic insert_ban(logic [31:0] a, inout logic bn, inout logic full);
      int slot;
      slot = -1;
      if (find_banned(a) < 0) begin
         for (int i = BAN_ENTRIES - 1; i >= 0; i--)
            if (!ban_used[i]) slot = i;
         if (slot < 0) begin
            full = 1'b1;
         end else begin
            ban_used[slot]  = 1'b1;
            ban_addr[slot]  = a;
            ban_start[slot] = now;
            bn = 1'b1;
         end
      end
   endtask

   // apply one accepted command to the table copy, queue what it causes
   task automatic predict_command(logic [2:0] c, logic [31:0] a);
      logic ok, bn, full;
      int slot;
      ok = 1'b0; bn = 1'b0; full = 1'b0;
      if (c == CMD_TICK) begin
         now = now + 32'd1;
         for (int i = 0; i < BAN_ENTRIES; i++)
            if (ban_used[i] && (now - ban_start[i]) >= ban_len) begin
               ban_used[i] = 1'b0;
               push_rsp(EV_LIFTED, ban_addr[i], 1'b1, 1'b0, 1'b0, 1'b0);
            end
         for (int i = 0; i < COUNT_ENTRIES; i++)
            if (cnt_used[i] && (now - cnt_start[i]) >= window) cnt_used[i] = 1'b0;
         push_rsp(EV_TICK, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1);
      end else begin
         case (c)
            CMD_FAIL: begin
               if (!is_allowed(a)) begin
                  ok = 1'b1;
                  slot = find_counter(a);
                  if (slot < 0) begin
                     for (int i = COUNT_ENTRIES - 1; i >= 0; i--)
                        if (!cnt_used[i]) slot = i;
                     if (slot < 0) begin
                        full = 1'b1;
                     end else begin
                        cnt_used[slot]  = 1'b1;
                        cnt_addr[slot]  = a;
                        cnt_val[slot]   = 8'd1;
                        cnt_start[slot] = now;
                     end
                  end else begin
                     if (cnt_val[slot] != 8'hFF) cnt_val[slot] = cnt_val[slot] + 8'd1;
                     if (cnt_val[slot] >= lim) begin
                        insert_ban(a, bn, full);
                        cnt_used[slot] = 1'b0;
                     end
                  end
               end
            end
            CMD_UNFAIL: begin
               slot = find_counter(a);
               if (slot >= 0) begin
                  cnt_used[slot] = 1'b0;
                  ok = 1'b1;
               end
            end
            CMD_BAN: begin
               if (!is_allowed(a)) begin
                  ok = 1'b1;
                  insert_ban(a, bn, full);
               end
            end
            CMD_QUERY: ok = (find_banned(a) >= 0);
            default: ;
         endcase
         push_rsp(EV_REPLY, a, ok, bn, full, 1'b1);
      end
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic compare_rsp();
      rsp_type e;
      if (expected_rsps.size() == 0) begin
         report("unexpected result, address", rsp.address_out, 32'd0);
      end else begin
         e = expected_rsps.pop_front();
         if (rsp.event_kind !== e.event_kind) report("event_kind", rsp.event_kind, e.event_kind);
         if (rsp.address_out !== e.address_out)
            report("address_out", rsp.address_out, e.address_out);
         if (rsp.ok !== e.ok) report("ok", rsp.ok, e.ok);
         if (rsp.banned_now !== e.banned_now) report("banned_now", rsp.banned_now, e.banned_now);
         if (rsp.table_full !== e.table_full) report("table_full", rsp.table_full, e.table_full);
         if (rsp.last !== e.last) report("last", rsp.last, e.last);
      end
   endtask

   initial errors = 0;

   // results first: a result never belongs to a transaction accepted at the same edge
   always @(posedge clock) begin
      if (reset) begin
         lim = 8'd5; window = 32'd600; ban_len = 32'd3600; allow_n = 3'd0;
         for (int i = 0; i < ALLOW_ENTRIES; i++) allow_addr[i] = 32'd0;
         for (int i = 0; i < COUNT_ENTRIES; i++) cnt_used[i] = 1'b0;
         for (int i = 0; i < BAN_ENTRIES; i++) ban_used[i] = 1'b0;
         now = 32'd0;
         expected_rsps.delete();
      end else begin
         if (rsp.valid && rsp.ready) compare_rsp();
         if (req.valid && req.ready) predict_command(req.command, req.address);
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_FAIL_LIMIT:  lim = csr.data[7:0];
               REG_FAIL_WINDOW: window = csr.data;
               REG_BAN_LENGTH:  ban_len = csr.data;
               REG_ALLOW_0:     allow_addr[0] = csr.data;
               REG_ALLOW_1:     allow_addr[1] = csr.data;
               REG_ALLOW_2:     allow_addr[2] = csr.data;
               REG_ALLOW_3:     allow_addr[3] = csr.data;
               REG_ALLOW_USED:  allow_n = csr.data[2:0];
               default: ;
            endcase
         end
      end
      waiting = expected_rsps.size();
   end

endmodule

// File: tb/failure_ban_table_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the failure ban table.
`timescale 1ns / 1ps
module failure_ban_table_tb;
   import fbt_pkg::*;

   localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
   localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int POOL_SIZE    = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors;
   int   waiting;
   int   hold_reqs = 0;
   int   hold_seen = 0;
   int   hold_left = 0;
   int   run_left = 0;
   int   stall_left = 0;
   int   burst_left = 0;
   int   quiet_cycles = 0;

   fbt_req_if req_ch ();
   fbt_rsp_if rsp_ch ();
   fbt_csr_if csr_ch ();

   failure_ban_table dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   failure_ban_table_checker checker_i (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .csr     (csr_ch),
      .errors  (errors),
      .waiting (waiting)
   );

   always #10 clock = ~clock;

   // pool of recurring addresses so that counters grow and the tables fill
   function automatic logic [31:0] pool_addr(int i);
      if (i == 0) return 32'd0;
      if (i == 1) return 32'hFFFF_FFFF;
      return 32'h0A00_0000 + i;
   endfunction

   // receiver: random run/stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (hold_reqs != hold_seen) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (run_left == 0 && stall_left == 0) begin
            run_left   = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 15);
            stall_left = $urandom_range(0, 6);
         end
         if (run_left > 0) begin
            run_left--;
            rsp_ch.ready <= 1'b1;
         end else begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("failure_ban_table_tb: done, errors");
         $finish;
      end
   end

   // offer one transaction inside a burst; keep valid high across a burst
   task automatic offer(logic [2:0] c, logic [31:0] a);
      int  gap;
      logic took;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.command <= c;
      req_ch.address <= a;
      do begin
         @(negedge clock);
         took = req_ch.ready;
         @(posedge clock);
      end while (!took);
   endtask

   // pause the sender until every expected result has come
   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      logic took;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do begin
         @(negedge clock);
         took = csr_ch.ready;
         @(posedge clock);
      end while (!took);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(logic [7:0] l, logic [31:0] w, logic [31:0] b, logic [2:0] n);
      write_reg(REG_FAIL_LIMIT, {24'($urandom), l});
      write_reg(REG_FAIL_WINDOW, w);
      write_reg(REG_BAN_LENGTH, b);
      write_reg(REG_ALLOW_0, pool_addr($urandom_range(0, POOL_SIZE - 1)));
      write_reg(REG_ALLOW_1, pool_addr($urandom_range(0, POOL_SIZE - 1)));
      write_reg(REG_ALLOW_2, pool_addr($urandom_range(0, POOL_SIZE - 1)));
      write_reg(REG_ALLOW_3, pool_addr($urandom_range(0, POOL_SIZE - 1)));
      write_reg(REG_ALLOW_USED, {29'($urandom), n});
   endtask

   // random transaction: mostly pool addresses, weighted toward fails and ticks
   task automatic offer_random();
      logic [2:0]  c;
      logic [31:0] a;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      c = CMD_FAIL;
      else if (pick < 60) c = CMD_TICK;
      else if (pick < 72) c = CMD_BAN;
      else if (pick < 84) c = CMD_QUERY;
      else if (pick < 95) c = CMD_UNFAIL;
      else                c = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
      a = ($urandom_range(0, 9) < 7) ? pool_addr($urandom_range(0, POOL_SIZE - 1)) : $urandom;
      offer(c, a);
   endtask

   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_FAIL;
      req_ch.address <= 32'd0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= REG_FAIL_LIMIT;
      csr_ch.data    <= 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, fail up to the limit, unfail, ban twice, query, undefined
      repeat (5) offer(CMD_FAIL, 32'hFFFF_FFFF);
      offer(CMD_QUERY, 32'hFFFF_FFFF);
      offer(CMD_QUERY, 32'd0);
      offer(CMD_UNFAIL, 32'd0);
      offer(CMD_FAIL, 32'd0);
      offer(CMD_UNFAIL, 32'd0);
      offer(CMD_BAN, 32'h1234_5678);
      offer(CMD_BAN, 32'h1234_5678);
      offer(CMD_TICK, 32'hDEAD_BEEF);
      offer(CMD_UNDEF_LO, 32'h5555_AAAA);
      offer(CMD_UNDEF_HI, 32'hAAAA_5555);
      drain();

      // directed: whitelist, limit zero, short bans lifted by ticks
      write_reg(REG_FAIL_LIMIT, 32'd0);
      write_reg(REG_FAIL_WINDOW, 32'd2);
      write_reg(REG_BAN_LENGTH, 32'd3);
      write_reg(REG_ALLOW_0, 32'h0A00_0005);
      write_reg(REG_ALLOW_USED, 32'd1);
      offer(CMD_FAIL, 32'h0A00_0005);
      offer(CMD_BAN, 32'h0A00_0005);
      offer(CMD_FAIL, 32'h0A00_0006);
      offer(CMD_FAIL, 32'h0A00_0006);
      offer(CMD_FAIL, 32'h0A00_0007);
      repeat (4) offer(CMD_TICK, 32'd0);
      offer(CMD_UNFAIL, 32'h0A00_0007);
      drain();

      // random phases across settings, extremes first
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_all(8'd0, 32'd0, 32'd0, 3'd0);
            1: write_all(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
            2: write_all(8'd3, 32'd10, 32'd12, 3'd2);
            3: write_all(8'd1, 32'd3, 32'd40, 3'd5);
            default: write_all(8'($urandom_range(1, 6)), $urandom_range(2, 30),
                               $urandom_range(5, 60), 3'($urandom_range(0, 7)));
         endcase
         for (int n = 0; n < 31; n++) begin
            if (ph == 2 && n == 5) begin
               @(negedge clock);
               hold_reqs++;
            end
            if (ph == 3 && n == 17) drain();
            offer_random();
         end
         drain();
      end

      if (errors == 0) begin
         $display("failure_ban_table_tb: done, clean");
      end else begin
         $display("failure_ban_table_tb: done, errors");
      end
      $finish;
   end

endmodule

// File: files.f
sv/fbt_pkg.sv
sv/fbt_if.sv
sv/fbt_ctrl.sv
sv/fbt_dp.sv
sv/failure_ban_table.sv
tb/failure_ban_table_checker.sv
tb/failure_ban_table_tb.sv
